/* hw/rtl/pidm_pkg.sv */
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types and constants for the multimode PID controller.
// ----------------------------------------------------------------------------
package pidm_pkg;

  // Error gate and encoder wrap constants
  localparam int DEADBAND  = 1;
  localparam int WRAP_SPAN = 8191;

  // Depth of the request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Operation codes carried from front to back
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_GATED = 2'd1;
  localparam logic [1:0] OP_POS   = 2'd2;
  localparam logic [1:0] OP_INC   = 2'd3;

  // Mode register codes
  localparam logic [2:0] MODE_POS      = 3'd0;
  localparam logic [2:0] MODE_INC      = 3'd1;
  localparam logic [2:0] MODE_POS_WRAP = 3'd2;
  localparam logic [2:0] MODE_POS_FREE = 3'd3;

  // Configuration register file contents
  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] kv;
    logic        [14:0] max_output;
    logic        [14:0] integral_limit;
    logic        [15:0] max_error;
  } pidm_cfg_t;

  // Classified request: operation plus the multiplier operands
  typedef struct packed {
    logic [1:0]         op;
    logic               inc_gate;
    logic signed [18:0] x_p;
    logic signed [17:0] x_i;
    logic signed [19:0] x_d;
    logic signed [18:0] x_v;
  } pidm_req_t;

endpackage

/* hw/rtl/pidm_regs.sv */
// ----------------------------------------------------------------------------
// pidm_regs
// APB-style configuration registers with reset defaults and read back.
// ----------------------------------------------------------------------------
module pidm_regs
  import pidm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pidm_cfg_t   cfg
);

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_KP        = 3'd1;
  localparam logic [2:0] REG_KI        = 3'd2;
  localparam logic [2:0] REG_KD        = 3'd3;
  localparam logic [2:0] REG_KV        = 3'd4;
  localparam logic [2:0] REG_MAX_OUT   = 3'd5;
  localparam logic [2:0] REG_INT_LIMIT = 3'd6;
  localparam logic [2:0] REG_MAX_ERR   = 3'd7;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_POS;
      cfg.kp             <= '0;
      cfg.ki             <= '0;
      cfg.kd             <= '0;
      cfg.kv             <= '0;
      cfg.max_output     <= 15'd16384;
      cfg.integral_limit <= '0;
      cfg.max_error      <= 16'd16384;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:      cfg.mode           <= pwdata[2:0];
        REG_KP:        cfg.kp             <= pwdata;
        REG_KI:        cfg.ki             <= pwdata;
        REG_KD:        cfg.kd             <= pwdata;
        REG_KV:        cfg.kv             <= pwdata;
        REG_MAX_OUT:   cfg.max_output     <= pwdata[14:0];
        REG_INT_LIMIT: cfg.integral_limit <= pwdata[14:0];
        REG_MAX_ERR:   cfg.max_error      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      REG_MODE:      prdata = {29'd0, cfg.mode};
      REG_KP:        prdata = cfg.kp;
      REG_KI:        prdata = cfg.ki;
      REG_KD:        prdata = cfg.kd;
      REG_KV:        prdata = cfg.kv;
      REG_MAX_OUT:   prdata = {17'd0, cfg.max_output};
      REG_INT_LIMIT: prdata = {17'd0, cfg.integral_limit};
      REG_MAX_ERR:   prdata = {16'd0, cfg.max_error};
      default:       prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/pidm_front.sv */
// ----------------------------------------------------------------------------
// pidm_front
// Accepts sample pairs, forms and wraps the error, applies the gate,
// keeps the error and measurement history and classifies each request.
// ----------------------------------------------------------------------------
module pidm_front
  import pidm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  pidm_cfg_t          cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] measured,
  input  logic signed [15:0] target,
  input  logic               q_full,
  output logic               q_push,
  output pidm_req_t          q_req
);

  localparam logic signed [17:0] HALF = 18'(WRAP_SPAN / 2);
  localparam logic signed [17:0] SPAN = 18'(WRAP_SPAN);

  logic signed [17:0] error_prev, error_prev2;
  logic signed [15:0] measured_prev, measured_prev2;

  logic signed [17:0] err_raw, err_wrap, err_use;
  logic               gate_raw, gate_wrap;
  logic               is_pos, is_inc, pos_gated, upd;

  function automatic logic gate_hit(input logic signed [17:0] e, input logic [15:0] lim);
    logic [17:0] a;
    logic        hit;
    a   = e[17] ? 18'(-e) : 18'(e);
    hit = 1'b0;
    if (lim != 16'd0 && a > 18'(lim)) hit = 1'b1;
    if (DEADBAND != 0 && a < 18'(DEADBAND)) hit = 1'b1;
    return hit;
  endfunction

  // Form, wrap and gate the error
  always_comb begin
    err_raw = 18'(target) - 18'(measured);
    if (err_raw >= HALF) begin
      err_wrap = err_raw - SPAN;
    end else if (err_raw <= -HALF) begin
      err_wrap = err_raw + SPAN;
    end else begin
      err_wrap = err_raw;
    end
    gate_raw  = gate_hit(err_raw, cfg.max_error);
    gate_wrap = gate_hit(err_wrap, cfg.max_error);
    is_inc    = (cfg.mode == MODE_INC);
    is_pos    = (cfg.mode == MODE_POS) || (cfg.mode == MODE_POS_WRAP) ||
                (cfg.mode == MODE_POS_FREE);
    pos_gated = ((cfg.mode == MODE_POS) || (cfg.mode == MODE_POS_WRAP)) && gate_raw;
    err_use   = (is_inc || cfg.mode == MODE_POS_WRAP) ? err_wrap : err_raw;
    upd       = is_inc || (is_pos && !pos_gated);
  end

  // Classify and build the multiplier operands
  always_comb begin
    q_req.inc_gate = is_inc && gate_wrap;
    q_req.x_i      = err_use;
    if (is_inc) begin
      q_req.op  = OP_INC;
      q_req.x_p = 19'(err_use) - 19'(error_prev);
      q_req.x_d = 20'(err_use) - (20'(error_prev) <<< 1) + 20'(error_prev2);
      q_req.x_v = 19'(measured) - (19'(measured_prev) <<< 1) + 19'(measured_prev2);
    end else begin
      if (!is_pos) begin
        q_req.op = OP_IDLE;
      end else if (pos_gated) begin
        q_req.op = OP_GATED;
      end else begin
        q_req.op = OP_POS;
      end
      q_req.x_p = 19'(err_use);
      q_req.x_d = 20'(err_use) - 20'(error_prev);
      q_req.x_v = 19'(measured) - 19'(measured_prev);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Advance the history on every request that updates state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_prev     <= '0;
      error_prev2    <= '0;
      measured_prev  <= '0;
      measured_prev2 <= '0;
    end else if (q_push && upd) begin
      error_prev2    <= error_prev;
      error_prev     <= err_use;
      measured_prev2 <= measured_prev;
      measured_prev  <= measured;
    end
  end

endmodule

/* hw/rtl/pidm_queue.sv */
// ----------------------------------------------------------------------------
// pidm_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module pidm_queue
  import pidm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pidm_req_t push_req,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output pidm_req_t head
);

  pidm_req_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push, do_pop;

  assign full    = (count == (QPTR_W + 1)'(QDEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/pidm_back.sv */
// ----------------------------------------------------------------------------
// pidm_back
// Execution pipeline: gain multiplies, term sums with the integral
// accumulator, output saturation and the registered result.
// ----------------------------------------------------------------------------
module pidm_back
  import pidm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pidm_cfg_t          cfg,
  input  logic               q_valid,
  input  pidm_req_t          q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] drive,
  output logic               gated
);

  localparam int IACC_W = FRAC_BITS + 17;
  localparam int PROD_W = 52;
  localparam int SUM_W  = 56;

  function automatic logic signed [SUM_W-1:0] sat(input logic signed [SUM_W-1:0] v,
                                                  input logic signed [SUM_W-1:0] lim);
    logic signed [SUM_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic en;

  // Stage A: products
  logic                     a_valid, a_gate;
  logic [1:0]               a_op;
  logic signed [PROD_W-1:0] a_pk, a_pi, a_pd, a_pv;
  logic signed [PROD_W-1:0] pk, pi, pd, pv;

  // Stage B: partial sum
  logic                     b_valid, b_gate;
  logic [1:0]               b_op;
  logic signed [SUM_W-1:0]  b_sum, sum_next, iout, iacc_next;

  // State
  logic signed [IACC_W-1:0] iacc;
  logic signed [15:0]       inc_out;

  // Limits and final totals
  logic signed [SUM_W-1:0]  int_lim, out_lim, pos_total, inc_total;
  logic signed [15:0]       pos_drive, inc_drive, drive_next;
  logic                     gated_next;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  assign int_lim = SUM_W'(cfg.integral_limit) << FRAC_BITS;
  assign out_lim = SUM_W'(cfg.max_output) << FRAC_BITS;

  // Multiply operands by their gains
  assign pk = cfg.kp * q_req.x_p;
  assign pi = cfg.ki * q_req.x_i;
  assign pd = cfg.kd * q_req.x_d;
  assign pv = cfg.kv * q_req.x_v;

  // Sum proportional, derivative and feedback terms; clamp the integral
  always_comb begin
    iout      = sat(SUM_W'(a_pi), int_lim);
    sum_next  = SUM_W'(a_pk) + SUM_W'(a_pd) - SUM_W'(a_pv);
    if (a_op == OP_INC) begin
      sum_next = sum_next + iout;
    end
    iacc_next = sat(SUM_W'(iacc) + SUM_W'(a_pi), int_lim);
  end

  // Add the stored term, saturate and drop the fraction
  always_comb begin
    pos_total = sat(b_sum + SUM_W'(iacc), out_lim);
    inc_total = sat((SUM_W'(inc_out) <<< FRAC_BITS) + b_sum, out_lim);
    pos_drive = 16'(pos_total >>> FRAC_BITS);
    inc_drive = 16'(inc_total >>> FRAC_BITS);
    case (b_op)
      OP_POS: begin
        drive_next = pos_drive;
        gated_next = 1'b0;
      end
      OP_INC: begin
        drive_next = b_gate ? 16'sd0 : inc_drive;
        gated_next = b_gate;
      end
      OP_GATED: begin
        drive_next = 16'sd0;
        gated_next = 1'b1;
      end
      default: begin
        drive_next = 16'sd0;
        gated_next = 1'b0;
      end
    endcase
  end

  // Hold or advance stage valids and state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      iacc      <= '0;
      inc_out   <= '0;
    end else if (en) begin
      a_valid   <= q_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
      if (a_valid && a_op == OP_POS) begin
        iacc <= IACC_W'(iacc_next);
      end
      if (b_valid && b_op == OP_INC) begin
        inc_out <= inc_drive;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= q_req.op;
      a_gate <= q_req.inc_gate;
      a_pk   <= pk;
      a_pi   <= pi;
      a_pd   <= pd;
      a_pv   <= pv;
      b_op   <= a_op;
      b_gate <= a_gate;
      b_sum  <= sum_next;
      drive  <= drive_next;
      gated  <= gated_next;
    end
  end

endmodule

/* hw/rtl/pid_controller_multimode.sv */
// ----------------------------------------------------------------------------
// pid_controller_multimode
// Multimode PID controller: gated, wrapped and ungated positional modes
// and an incremental mode, with measurement feedback and saturation.
// ----------------------------------------------------------------------------
//  port group   | direction | handshake          | payload
//  -------------+-----------+--------------------+-----------------------
//  sample in    | in        | in_valid/in_ready  | measured, target
//  drive out    | out       | out_valid/out_ready| drive, gated
//  config       | in        | psel/penable/pready| paddr, pwdata, prdata
//
// One request per cycle while out_ready holds; a request moves from the queue
// head to multiply stage, sum stage and output register, raising out_valid.
// The integral and incremental feedback each close in a single stage.
// Reset restores register defaults, clears history and empties the queue.
// A stalled output holds the back pipeline; the queue keeps the front
// accepting until it fills.
// ----------------------------------------------------------------------------
module pid_controller_multimode
  import pidm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] measured,
  input  logic signed [15:0] target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] drive,
  output logic               gated
);

  pidm_cfg_t cfg;
  pidm_req_t push_req, head;
  logic      q_full, q_push, q_pop, q_valid;

  pidm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .measured (measured),
    .target   (target),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (push_req)
  );

  pidm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  pidm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_req     (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .gated     (gated)
  );

endmodule
